// ----- src/alr_pkg.sv -----
// shared types, band table and ramp step tables for the ambient light entry ramp
package alr_pkg;

    // field widths
    localparam int unsigned SAMPLE_W  = 10;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned TOP_W     = 16;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned STEP_DEPTH = 16;

    // duty times pwm_top, and the reciprocal used to divide it by one hundred
    localparam int unsigned PROD_W      = PCT_W + TOP_W;
    localparam int unsigned RECIP_W     = 24;
    localparam int unsigned RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    // scaling constants
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;
    localparam logic [PCT_W-1:0]    PERCENT    = 7'd100;
    localparam logic [TOP_W-1:0]    PWM_TOP_RESET = 16'd1023;

    // command codes carried in tuser
    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // lamp mode codes
    localparam logic MODE_DAY   = 1'b0;
    localparam logic MODE_NIGHT = 1'b1;

    typedef struct packed {
        logic [PCT_W-1:0] lo;
        logic [PCT_W-1:0] hi;
        logic [PCT_W-1:0] start;
        logic             night;
    } band_t;

    localparam int unsigned NUM_BANDS = 5;

    localparam band_t BANDS [NUM_BANDS] = '{
        '{lo: 7'd0,  hi: 7'd20,  start: 7'd15, night: MODE_NIGHT},
        '{lo: 7'd21, hi: 7'd40,  start: 7'd20, night: MODE_NIGHT},
        '{lo: 7'd41, hi: 7'd50,  start: 7'd42, night: MODE_DAY},
        '{lo: 7'd51, hi: 7'd70,  start: 7'd80, night: MODE_DAY},
        '{lo: 7'd71, hi: 7'd100, start: 7'd90, night: MODE_DAY}
    };

    // per-step duty increments, zero past the last defined step
    localparam logic [PCT_W-1:0] NIGHT_STEPS [STEP_DEPTH] = '{
        7'd0, 7'd1, 7'd1, 7'd3, 7'd7, 7'd16, 7'd16, 7'd14,
        7'd12, 7'd10, 7'd8, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

    localparam logic [PCT_W-1:0] DAY_STEPS [STEP_DEPTH] = '{
        7'd0, 7'd4, 7'd7, 7'd16, 7'd44, 7'd59, 7'd59, 7'd55,
        7'd50, 7'd45, 7'd40, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0
    };

endpackage

// ----- src/ambient_light_entry_ramp.sv -----
// Throughput: one transaction per cycle while m_tready does not hold the output; the chain is
// input register, ramp state update, duty by pwm_top product, and the reciprocal scaling by
// one hundred into the output register.
// Ticks that yield no result still pass through the first two stages; triggers always yield one.
// Reset (rst_n, asynchronous, active low): ramp idle, step 0, duty 0, night mode,
// pwm_top 1023, all pipeline stages empty.
module ambient_light_entry_ramp #(
    parameter int unsigned RAMP_STEPS = 11
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: pwm_top
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] light_sample, [15:10] zero
    input  logic        s_tuser,   // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [6:0] lamp duty, [22:7] pwm compare, [23] night_mode
);

    localparam int unsigned NEXT_W = alr_pkg::STEP_W + 1;
    localparam logic [NEXT_W-1:0] STEP_LIMIT = NEXT_W'(RAMP_STEPS);
    localparam int unsigned MUL_W = alr_pkg::PROD_W + alr_pkg::RECIP_W;

    // configuration register
    logic [alr_pkg::TOP_W-1:0] pwm_top_reg;

    // stage 1: input register
    logic                         in_valid_reg;
    logic                         cmd_reg;
    logic [alr_pkg::SAMPLE_W-1:0] sample_reg;

    // stage 2: ramp state, which also carries the result payload
    logic                        s2_valid_reg;
    logic                        running_reg;
    logic [alr_pkg::STEP_W-1:0]  step_reg;
    logic [alr_pkg::PCT_W-1:0]   duty_reg;
    logic                        night_reg;

    // stage 3: product
    logic                         s3_valid_reg;
    logic [alr_pkg::PROD_W-1:0]   prod_reg;
    logic [alr_pkg::PCT_W-1:0]    duty3_reg;
    logic                         night3_reg;

    // stage 4: output register
    logic                         out_valid_reg;
    logic [alr_pkg::TOP_W-1:0]    compare_reg;
    logic [alr_pkg::PCT_W-1:0]    duty_out_reg;
    logic                         night_out_reg;

    // stage load enables
    logic load2;
    logic load3;
    logic load4;
    logic fire2;

    // stage 2 next values
    logic                        running_next;
    logic [alr_pkg::STEP_W-1:0]  step_next;
    logic [alr_pkg::PCT_W-1:0]   duty_next;
    logic                        night_next;
    logic                        has_result;

    // perceived level and band pick
    logic [16:0]                 scaled;
    logic [alr_pkg::PCT_W-1:0]   approx;
    logic [alr_pkg::PCT_W-1:0]   approx_p1;
    logic [16:0]                 approx_back;
    logic [alr_pkg::PCT_W-1:0]   quot;
    logic [alr_pkg::PCT_W-1:0]   level;
    alr_pkg::band_t              band;

    // tick path
    logic [NEXT_W-1:0]           next_idx;
    logic [alr_pkg::PCT_W-1:0]   inc;
    logic [alr_pkg::PCT_W:0]     sum;

    logic [MUL_W-1:0]            scaled_prod;

    // handshake: each stage loads when empty or when it drains downstream
    assign load4    = !out_valid_reg || m_tready;
    assign load3    = !s3_valid_reg || load4;
    assign load2    = !s2_valid_reg || load3;
    assign s_tready = !in_valid_reg || load2;
    assign fire2    = in_valid_reg && load2;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_top_reg <= alr_pkg::PWM_TOP_RESET;
        end
        else if (cfg_we)
        begin
            pwm_top_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            cmd_reg    <= s_tuser;
            sample_reg <= s_tdata[alr_pkg::SAMPLE_W-1:0];
        end
    end

    // perceived level: 100 - sample*100/1023, quotient from a shift plus one correction
    always_comb
    begin
        scaled      = 17'(sample_reg) * 17'(alr_pkg::PERCENT);
        approx      = scaled[16:10];
        approx_p1   = approx + 7'd1;
        approx_back = {approx_p1, 10'b0} - 17'(approx_p1);
        quot        = (approx_back <= scaled) ? approx_p1 : approx;
        level       = alr_pkg::PERCENT - quot;
    end

    // band pick, first matching row wins
    always_comb
    begin
        band = alr_pkg::BANDS[0];
        for (int i = alr_pkg::NUM_BANDS - 1; i >= 0; i--)
        begin
            if (level >= alr_pkg::BANDS[i].lo && level <= alr_pkg::BANDS[i].hi)
            begin
                band = alr_pkg::BANDS[i];
            end
        end
    end

    // ramp state update
    always_comb
    begin
        running_next = running_reg;
        step_next    = step_reg;
        duty_next    = duty_reg;
        night_next   = night_reg;
        has_result   = 1'b0;
        next_idx     = NEXT_W'(step_reg) + NEXT_W'(1);
        inc          = night_reg ? alr_pkg::NIGHT_STEPS[next_idx[alr_pkg::STEP_W-1:0]]
                                 : alr_pkg::DAY_STEPS[next_idx[alr_pkg::STEP_W-1:0]];
        sum          = {1'b0, duty_reg} + {1'b0, inc};
        if (cmd_reg == alr_pkg::CMD_TRIGGER)
        begin
            running_next = 1'b1;
            step_next    = '0;
            duty_next    = band.start;
            night_next   = band.night;
            has_result   = 1'b1;
        end
        else if (running_reg)
        begin
            step_next = next_idx[alr_pkg::STEP_W-1:0];
            if (next_idx >= STEP_LIMIT)
            begin
                running_next = 1'b0;
            end
            else
            begin
                duty_next  = (sum > {1'b0, alr_pkg::PERCENT}) ? alr_pkg::PERCENT
                                                              : sum[alr_pkg::PCT_W-1:0];
                has_result = 1'b1;
            end
        end
    end

    // stage 2 registers; state moves only when the stage is free to take a new payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            running_reg  <= 1'b0;
            step_reg     <= '0;
            duty_reg     <= '0;
            night_reg    <= alr_pkg::MODE_NIGHT;
        end
        else
        begin
            if (load2)
            begin
                s2_valid_reg <= fire2 && has_result;
            end
            if (fire2)
            begin
                running_reg <= running_next;
                step_reg    <= step_next;
                duty_reg    <= duty_next;
                night_reg   <= night_next;
            end
        end
    end

    // stage 3: duty times pwm_top
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (load3)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            prod_reg   <= alr_pkg::PROD_W'(duty_reg) * alr_pkg::PROD_W'(pwm_top_reg);
            duty3_reg  <= duty_reg;
            night3_reg <= night_reg;
        end
    end

    // stage 4: divide by one hundred through the reciprocal, exact over the product range
    assign scaled_prod = MUL_W'(prod_reg) * MUL_W'(alr_pkg::RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load4)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load4)
        begin
            compare_reg   <= scaled_prod[alr_pkg::RECIP_SHIFT +: alr_pkg::TOP_W];
            duty_out_reg  <= duty3_reg;
            night_out_reg <= night3_reg;
        end
    end

    // result transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {night_out_reg, compare_reg, duty_out_reg};

    // a tick taken while idle produces no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire2 && cmd_reg == alr_pkg::CMD_TICK && !running_reg) |=> !s2_valid_reg)
    else $error("tick while idle produced a result");

    // a trigger restarts the ramp from step zero and always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire2 && cmd_reg == alr_pkg::CMD_TRIGGER) |=> (running_reg && step_reg == '0 &&
                                                       s2_valid_reg))
    else $error("trigger did not restart the ramp");

    // compare value never exceeds the counter top, and duty never exceeds one hundred
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (compare_reg <= pwm_top_reg && duty_out_reg <= alr_pkg::PERCENT))
    else $error("result out of range");

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench for the ambient light entry ramp: random stream traffic, ramp predictor
module tb_top;

    localparam int unsigned RAMP_LEN       = 11;
    localparam int unsigned SENSOR_FULL    = 1023;
    localparam int unsigned HUNDRED        = 100;
    localparam int unsigned SETTLE_CYCLES  = 12;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic       cmd;
        logic [9:0] sample;
    } ramp_item_t;

    // packed to match m_tdata: duty in the low bits, night mode on top
    typedef struct packed {
        logic        night;
        logic [15:0] compare;
        logic [6:0]  duty;
    } lamp_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = 16'd0;   // [9:0] light_sample, [15:10] zero
    logic        s_tuser   = 1'b0;    // [0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;             // [6:0] lamp duty, [22:7] pwm compare, [23] night_mode

    // stimulus and expectation stores
    ramp_item_t   ramp_item_q [$];
    lamp_result_t expected_lamp_q [$];
    ramp_item_t   offered;

    // predictor state
    logic              ramp_on       = 1'b0;
    logic [3:0]        ramp_step     = 4'd0;
    int unsigned       lamp_duty     = 0;
    logic              lamp_night    = alr_pkg::MODE_NIGHT;
    logic [15:0]       pwm_top_model = 16'd1023;

    // per-step duty increments, zero past the last defined step
    int unsigned night_inc [16] = '{0, 1, 1, 3, 7, 16, 16, 14, 12, 10, 8, 0, 0, 0, 0, 0};
    int unsigned day_inc   [16] = '{0, 4, 7, 16, 44, 59, 59, 55, 50, 45, 40, 0, 0, 0, 0, 0};

    // samples that land either side of each band boundary, plus the extremes
    logic [9:0] band_edges [10] = '{10'd0, 10'd1023, 10'd818, 10'd819, 10'd613,
                                    10'd614, 10'd511, 10'd512, 10'd306, 10'd307};

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        pressure_on   = 1'b0;
    logic        pressure_done = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned error_count   = 0;
    int unsigned triggers_sent = 0;
    int unsigned ticks_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned cfg_writes    = 0;

    ambient_light_entry_ramp #(
        .RAMP_STEPS(RAMP_LEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic logic [9:0] pick_sample();
        if ($urandom_range(99) < 30)
        begin
            return band_edges[$urandom_range(9)];
        end
        return 10'($urandom_range(SENSOR_FULL));
    endfunction

    // ramp behaviour for one accepted transaction
    task automatic predict_lamp(input ramp_item_t item);
        int unsigned  level;
        int unsigned  samp;
        int unsigned  next_step;
        logic         emit;
        lamp_result_t res;
        emit = 1'b0;
        if (item.cmd == alr_pkg::CMD_TRIGGER)
        begin
            samp  = item.sample;
            level = HUNDRED - (samp * HUNDRED) / SENSOR_FULL;
            // band pick sets start duty and lamp mode
            if (level <= 20)
            begin
                lamp_duty  = 15;
                lamp_night = alr_pkg::MODE_NIGHT;
            end
            else if (level <= 40)
            begin
                lamp_duty  = 20;
                lamp_night = alr_pkg::MODE_NIGHT;
            end
            else if (level <= 50)
            begin
                lamp_duty  = 42;
                lamp_night = alr_pkg::MODE_DAY;
            end
            else if (level <= 70)
            begin
                lamp_duty  = 80;
                lamp_night = alr_pkg::MODE_DAY;
            end
            else
            begin
                lamp_duty  = 90;
                lamp_night = alr_pkg::MODE_DAY;
            end
            ramp_step = 4'd0;
            ramp_on   = 1'b1;
            emit      = 1'b1;
        end
        else if (ramp_on)
        begin
            next_step = ramp_step + 1;
            ramp_step = next_step[3:0];
            if (next_step >= RAMP_LEN)
            begin
                // ramp finished, nothing leaves
                ramp_on = 1'b0;
            end
            else
            begin
                lamp_duty += (lamp_night == alr_pkg::MODE_NIGHT) ? night_inc[ramp_step]
                                                                 : day_inc[ramp_step];
                if (lamp_duty > HUNDRED)
                begin
                    lamp_duty = HUNDRED;
                end
                emit = 1'b1;
            end
        end
        if (emit)
        begin
            res.duty    = lamp_duty[6:0];
            res.compare = 16'((lamp_duty * pwm_top_model) / HUNDRED);
            res.night   = lamp_night;
            expected_lamp_q.push_back(res);
        end
    endtask

    // sender: offers queued items, predicts on every accepted transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_lamp(offered);
                if (offered.cmd == alr_pkg::CMD_TRIGGER)
                begin
                    triggers_sent++;
                end
                else
                begin
                    ticks_sent++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (ramp_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered  = ramp_item_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {6'd0, offered.sample};
                    s_tuser  <= offered.cmd;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each result transaction and drives back-pressure
    always @(posedge clk)
    begin
        lamp_result_t got;
        lamp_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = lamp_result_t'(m_tdata);
                results_seen++;
                if (expected_lamp_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected result: duty %0d compare %0d night %0b",
                                         got.duty, got.compare, got.night));
                end
                else
                begin
                    want = expected_lamp_q.pop_front();
                    if (got.duty !== want.duty || got.compare !== want.compare ||
                        got.night !== want.night)
                    begin
                        flag_error($sformatf({"result %0d: expected duty %0d compare %0d ",
                                              "night %0b, got duty %0d compare %0d night %0b"},
                                             results_seen, want.duty, want.compare, want.night,
                                             got.duty, got.compare, got.night));
                    end
                end
            end
            // one long hold-off so the pipeline fills and stalls the input
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (pressure_on && !pressure_done)
            begin
                pressure_done = 1'b1;
                hold_left     = LONG_HOLD;
                m_tready      <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // cycles with no transaction of any kind
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_lamp_q.size());
        $display("simulation failed");
        $finish;
    end

    task automatic queue_trigger(input logic [9:0] sample);
        ramp_item_t item;
        item.cmd    = alr_pkg::CMD_TRIGGER;
        item.sample = sample;
        ramp_item_q.push_back(item);
    endtask

    // ticks carry random sample bits, which the block ignores
    task automatic queue_tick();
        ramp_item_t item;
        item.cmd    = alr_pkg::CMD_TICK;
        item.sample = 10'($urandom_range(SENSOR_FULL));
        ramp_item_q.push_back(item);
    endtask

    // mostly whole ramps, cut short or run past their end, with stray items between
    task automatic queue_random_ramps(input int unsigned target);
        int unsigned made;
        int unsigned ticks;
        made = 0;
        while (made < target)
        begin
            if ($urandom_range(99) < 15)
            begin
                if ($urandom_range(1) == 1)
                begin
                    queue_tick();
                end
                else
                begin
                    queue_trigger(pick_sample());
                end
                made++;
            end
            else
            begin
                ticks = $urandom_range(13);
                queue_trigger(pick_sample());
                repeat (ticks) queue_tick();
                made += 1 + ((ticks < RAMP_LEN) ? ticks : RAMP_LEN);
            end
        end
    endtask

    // wait for everything to leave, then let silent items clear the pipeline
    task automatic drain();
        while (ramp_item_q.size() != 0 || s_tvalid || expected_lamp_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_pwm_top(input logic [15:0] value);
        @(posedge clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= value;
        pwm_top_model = value;
        cfg_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // main sequence
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset value of pwm_top, idle tick, full night ramp, saturation, bands
        send_idle_pct = 20;
        recv_idle_pct = 63;
        queue_tick();
        queue_trigger(10'd1023);
        repeat (RAMP_LEN) queue_tick();
        queue_tick();
        queue_trigger(10'd0);
        repeat (2) queue_tick();
        queue_trigger(10'd819);
        queue_trigger(10'd818);
        queue_trigger(10'd614);
        queue_trigger(10'd613);
        queue_trigger(10'd512);
        queue_trigger(10'd511);
        queue_trigger(10'd307);
        queue_trigger(10'd306);
        drain();

        // largest pwm_top, with the long receiver hold-off
        load_pwm_top(16'hFFFF);
        pressure_on = 1'b1;
        queue_random_ramps(200);
        drain();

        // receiver now mostly ready, sender sparse
        send_idle_pct = 63;
        recv_idle_pct = 20;
        load_pwm_top(16'd1);
        queue_random_ramps(200);
        drain();

        // zero pwm_top lies outside the range but is a legal register value
        load_pwm_top(16'd0);
        queue_random_ramps(100);
        drain();

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_pwm_top(16'($urandom_range(65534, 2)));
        queue_random_ramps(250);
        drain();

        load_pwm_top(16'd1023);
        queue_random_ramps(175);
        drain();

        if (expected_lamp_q.size() != 0)
        begin
            flag_error($sformatf("%0d expected results never arrived", expected_lamp_q.size()));
        end

        $display("covered %0d triggers and %0d ticks, %0d results checked, %0d pwm_top writes",
                 triggers_sent, ticks_sent, results_seen, cfg_writes);
        $display("mismatches and unexpected results: %0d", error_count);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
